>>> hdl/scmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scmm_pkg;
	localparam int DIM_DEF       = 64;
	localparam int B_DEPTH_DEF   = 4096;
	localparam int ROW_DEPTH_DEF = 64;
	localparam int IDX_W         = 6;
	localparam int VAL_W         = 16;
	localparam int SUM_W         = 40;
	localparam int PROD_W        = 32;
	localparam int OUT_MAX       = 64;

	localparam logic [1:0] FUNC_LOAD_B  = 2'd0;
	localparam logic [1:0] FUNC_A_ENTRY = 2'd1;
	localparam logic [1:0] FUNC_CLEAR_B = 2'd2;

	// Saturating add of a product into the running sum.
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]  s,
		input logic signed [PROD_W-1:0] p
	);
		logic signed [SUM_W:0] r;
		r = {s[SUM_W-1], s} + {{(SUM_W+1-PROD_W){p[PROD_W-1]}}, p};
		if (r[SUM_W] != r[SUM_W-1]) begin
			sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = r[SUM_W-1:0];
		end
	endfunction
endpackage
`default_nettype wire

>>> hdl/sparse_coo_matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// Sparse COO matrix multiply, one output row per A row.
// Input channel (valid/stall): each word carries func, entry_row, entry_col,
// entry_value and row_end. func selects a B load, an A entry or a B clear.
// Each B load, clear or A entry that does not end a row is followed by an input
// stall, as busy_q registers every accepted word. An A word with row_end starts
// the merge: the sequencer walks the B store once, run by run, through the eq
// and lt comparators and one multiply-accumulate unit. Each merge step (an A or
// B index advance, or both on a match) passes S_RUN_CMP and S_RUN_RD; each run
// adds S_RUN_START, S_RUN_COL, S_RUN_DRAIN, S_RUN_END, and S_EMIT to push a result.
// The input stalls for the whole merge and until the last word is taken.
// Output channel (valid/stall): each word is (out_row, out_col, out_value,
// out_last), emitted in B column order; out_last marks the final word of the
// row. When the receiver stalls, the sequencer holds until the output
// register is taken, so nothing is lost.
// Reset clears the B entry count and the A row count; the stores hold
// undefined data until written, and nothing past the counts is used.
// The row yields one result per run with a nonzero sum, up to OUT_MAX.
module sparse_coo_matrix_multiply import scmm_pkg::*; #(
	parameter int DIM       = DIM_DEF,
	parameter int B_DEPTH   = B_DEPTH_DEF,
	parameter int ROW_DEPTH = ROW_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    valid,
	output logic                         stall,
	input  wire logic [1:0]              func,
	input  wire logic [IDX_W-1:0]        entry_row,
	input  wire logic [IDX_W-1:0]        entry_col,
	input  wire logic signed [VAL_W-1:0] entry_value,
	input  wire logic                    row_end,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [IDX_W-1:0]             out_row,
	output logic [IDX_W-1:0]             out_col,
	output logic signed [SUM_W-1:0]      out_value,
	output logic                         out_last
);
	localparam int BA_W = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int BC_W = $clog2(B_DEPTH + 1);
	localparam int RA_W = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int RC_W = $clog2(ROW_DEPTH + 1);
	localparam int OC_W = $clog2(OUT_MAX + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RUN_START, S_RUN_COL, S_RUN_RD, S_RUN_CMP, S_RUN_DRAIN, S_RUN_END,
		S_EMIT, S_WAIT_OUT, S_FINISH
	} state_t;

	// Memories.
	logic [IDX_W-1:0]        b_rows_mem [B_DEPTH];
	logic [IDX_W-1:0]        b_cols_mem [B_DEPTH];
	logic signed [VAL_W-1:0] b_vals_mem [B_DEPTH];
	logic [IDX_W-1:0]        a_cols_mem [ROW_DEPTH];
	logic signed [VAL_W-1:0] a_vals_mem [ROW_DEPTH];

	state_t                  state_q;
	logic [BC_W-1:0]         b_count_q;
	logic [RC_W-1:0]         a_count_q;
	logic [BC_W-1:0]         jj_q;
	logic [RC_W-1:0]         ii_q;
	logic [IDX_W-1:0]        run_col_q;
	logic [IDX_W-1:0]        row_q;
	logic [OC_W-1:0]         n_q;
	logic                    busy_q;

	// Registered read data.
	logic [IDX_W-1:0]        b_row_rd_q, b_col_rd_q, a_col_rd_q;
	logic signed [VAL_W-1:0] b_val_rd_q, a_val_rd_q;

	// Pending result held for look-ahead so out_last can be set correctly.
	logic                    pend_q;
	logic [IDX_W-1:0]        pend_col_q;
	logic signed [SUM_W-1:0] pend_sum_q;

	logic                    mac_clr, mac_en, mac_busy;
	logic signed [SUM_W-1:0] mac_sum;

	logic in_acc, out_acc, in_range, out_load;
	assign in_acc   = valid && !stall;
	assign out_acc  = out_valid && !out_stall;
	assign in_range = (32'(entry_row) < DIM) && (32'(entry_col) < DIM);
	assign stall    = (state_q != S_IDLE) || busy_q;
	// The output register takes a new word when it is empty or being taken.
	assign out_load = ((state_q == S_EMIT) || (state_q == S_FINISH && pend_q)) &&
		(!out_valid || out_acc);

	scmm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (mac_clr),
		.en    (mac_en),
		.a     (a_val_rd_q),
		.b     (b_val_rd_q),
		.busy  (mac_busy),
		.sum   (mac_sum)
	);

	logic jj_in_run, ii_ok, eq, lt;
	assign jj_in_run = (jj_q < b_count_q) && (b_col_rd_q == run_col_q);
	assign ii_ok     = ii_q < a_count_q;
	assign eq        = a_col_rd_q == b_row_rd_q;
	assign lt        = a_col_rd_q < b_row_rd_q;

	assign mac_clr = (state_q == S_RUN_START);
	assign mac_en  = (state_q == S_RUN_CMP) && jj_in_run && ii_ok && eq;

	// Store writes and reads.
	always_ff @(posedge clk) begin
		if (in_acc && func == FUNC_LOAD_B && in_range && b_count_q < BC_W'(B_DEPTH)) begin
			b_rows_mem[b_count_q[BA_W-1:0]] <= entry_row;
			b_cols_mem[b_count_q[BA_W-1:0]] <= entry_col;
			b_vals_mem[b_count_q[BA_W-1:0]] <= entry_value;
		end
		if (in_acc && func == FUNC_A_ENTRY && in_range && a_count_q < RC_W'(ROW_DEPTH)) begin
			a_cols_mem[a_count_q[RA_W-1:0]] <= entry_col;
			a_vals_mem[a_count_q[RA_W-1:0]] <= entry_value;
		end
		b_row_rd_q <= b_rows_mem[jj_q[BA_W-1:0]];
		b_col_rd_q <= b_cols_mem[jj_q[BA_W-1:0]];
		b_val_rd_q <= b_vals_mem[jj_q[BA_W-1:0]];
		a_col_rd_q <= a_cols_mem[ii_q[RA_W-1:0]];
		a_val_rd_q <= a_vals_mem[ii_q[RA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			b_count_q  <= '0;
			a_count_q  <= '0;
			jj_q       <= '0;
			ii_q       <= '0;
			n_q        <= '0;
			busy_q     <= 1'b0;
			pend_q     <= 1'b0;
			pend_col_q <= '0;
			pend_sum_q <= '0;
			out_valid  <= 1'b0;
			out_last   <= 1'b0;
			out_row    <= '0;
			out_col    <= '0;
			out_value  <= '0;
			run_col_q  <= '0;
			row_q      <= '0;
		end else begin
			busy_q <= in_acc;
			if (out_acc && !out_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (func)
							FUNC_CLEAR_B: b_count_q <= '0;
							FUNC_LOAD_B: begin
								if (in_range && b_count_q < BC_W'(B_DEPTH)) begin
									b_count_q <= b_count_q + 1'b1;
								end
							end
							FUNC_A_ENTRY: begin
								if (in_range) begin
									if (a_count_q < RC_W'(ROW_DEPTH)) begin
										a_count_q <= a_count_q + 1'b1;
									end
									if (row_end) begin
										row_q   <= entry_row;
										jj_q    <= '0;
										n_q     <= '0;
										pend_q  <= 1'b0;
										state_q <= S_RUN_START;
									end
								end
							end
							default: ;
						endcase
					end
				end
				// Start a run at jj, or finish the row when B is exhausted or the result cap is reached.
				S_RUN_START: begin
					if (jj_q >= b_count_q || n_q == OC_W'(OUT_MAX)) begin
						state_q <= S_FINISH;
					end else begin
						ii_q    <= '0;
						state_q <= S_RUN_COL;
					end
				end
				// The first entry of the run fixes the run's column.
				S_RUN_COL: begin
					run_col_q <= b_col_rd_q;
					state_q   <= S_RUN_CMP;
				end
				S_RUN_RD: begin
					state_q <= S_RUN_CMP;
				end
				// Each merge step compares here, then rereads in S_RUN_RD; a column change ends the run.
				S_RUN_CMP: begin
					if (!jj_in_run) begin
						state_q <= S_RUN_DRAIN;
					end else if (!ii_ok) begin
						// Skip the rest of the run.
						jj_q    <= jj_q + 1'b1;
						state_q <= S_RUN_RD;
					end else begin
						if (eq) begin
							ii_q <= ii_q + 1'b1;
							jj_q <= jj_q + 1'b1;
						end else if (lt) begin
							ii_q <= ii_q + 1'b1;
						end else begin
							jj_q <= jj_q + 1'b1;
						end
						state_q <= S_RUN_RD;
					end
				end
				S_RUN_DRAIN: begin
					if (!mac_busy) begin
						state_q <= S_RUN_END;
					end
				end
				S_RUN_END: begin
					if (mac_sum != '0) begin
						if (pend_q) begin
							state_q <= S_EMIT;
						end else begin
							pend_q     <= 1'b1;
							pend_col_q <= run_col_q;
							pend_sum_q <= mac_sum;
							n_q        <= n_q + 1'b1;
							state_q    <= S_RUN_START;
						end
					end else begin
						state_q <= S_RUN_START;
					end
				end
				// Flush the older pending result, keep the new one.
				S_EMIT: begin
					if (out_load) begin
						out_valid  <= 1'b1;
						out_row    <= row_q;
						out_col    <= pend_col_q;
						out_value  <= pend_sum_q;
						out_last   <= 1'b0;
						pend_col_q <= run_col_q;
						pend_sum_q <= mac_sum;
						n_q        <= n_q + 1'b1;
						state_q    <= S_RUN_START;
					end
				end
				S_FINISH: begin
					if (!pend_q) begin
						a_count_q <= '0;
						state_q   <= S_WAIT_OUT;
					end else if (out_load) begin
						out_valid <= 1'b1;
						out_row   <= row_q;
						out_col   <= pend_col_q;
						out_value <= pend_sum_q;
						out_last  <= 1'b1;
						pend_q    <= 1'b0;
						a_count_q <= '0;
						state_q   <= S_WAIT_OUT;
					end
				end
				S_WAIT_OUT: begin
					if (!out_valid || out_acc) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The A read index never runs past the buffered count during a merge step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN_CMP || state_q == S_RUN_RD || state_q == S_RUN_DRAIN)
		|-> ii_q <= a_count_q)
		else $error("A index past row count");
	// No more results than the cap are emitted per row.
	assert property (@(posedge clk) disable iff (!arst_n) n_q <= OC_W'(OUT_MAX))
		else $error("result count over cap");
	// The input is stalled throughout a merge.
	assert property (@(posedge clk) disable iff (!arst_n) state_q != S_IDLE |-> stall)
		else $error("input open during merge");
	// A held output value and out_last do not change while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_last))
		else $error("stalled output changed");
endmodule
`default_nettype wire

>>> hdl/scmm_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// Multiply-accumulate unit: product registered, then saturated add into the sum.
module scmm_mac import scmm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clr,
	input  wire logic                     en,
	input  wire logic signed [VAL_W-1:0]  a,
	input  wire logic signed [VAL_W-1:0]  b,
	output logic                          busy,
	output logic signed [SUM_W-1:0]       sum
);
	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic signed [SUM_W-1:0]  sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sum_q  <= '0;
		end else begin
			vld_s1 <= en;
			if (clr) begin
				sum_q <= '0;
			end else if (vld_s1) begin
				sum_q <= sat_add(sum_q, prod_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign busy = vld_s1;
	assign sum  = sum_q;
endmodule
`default_nettype wire
